@@ src/pqdk_pkg.sv @@
`timescale 1ns / 1ps

package pqdk_pkg;

  localparam int ID_W   = 16;
  localparam int PRI_W  = 16;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 5;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_UPGRADE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_URGENT = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd4;

  typedef struct packed {
    cmd_t             cmd;
    logic [ID_W-1:0]  entry_id;
    logic [PRI_W-1:0] entry_priority;
  } item_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   removed_id;
    logic [ID_W-1:0]   front_id;
    logic [PRI_W-1:0]  front_priority;
    logic              is_empty;
    logic [CNT_W-1:0]  entry_count;
  } item_out_t;

  // one slot of the queue
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } slot_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_TAKE_OUT
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t         op;
    logic [ID_W-1:0]  key_id;
    logic [PRI_W-1:0] key_pri;
  } cell_ctl_t;

endpackage

@@ src/pqdk_cell.sv @@
`timescale 1ns / 1ps

module pqdk_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  logic               clk,
  input  pqdk_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      count,
  input  pqdk_pkg::slot_t    left,
  input  logic               left_after,
  input  pqdk_pkg::slot_t    right,
  input  logic               seen_in,
  input  logic [pqdk_pkg::PRI_W-1:0] found_pri_in,
  output pqdk_pkg::slot_t    slot,
  output logic               after,
  output logic               seen_out,
  output logic [pqdk_pkg::PRI_W-1:0] found_pri_out
);
  import pqdk_pkg::*;

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic  held;
  logic  match;
  slot_t slot_next;

  assign held          = count > IDX;
  assign after         = held && (slot.pri <= ctl.key_pri);
  assign match         = held && (slot.id == ctl.key_id);
  assign seen_out      = seen_in || match;
  assign found_pri_out = seen_in ? found_pri_in : slot.pri;

  always_comb begin
    slot_next = slot;
    unique case (ctl.op)
      CELL_HOLD: begin
        slot_next = slot;
      end
      CELL_INSERT: begin
        // slots of lower or equal priority stay, the rest move one place back
        if (!after) begin
          slot_next = left_after ? slot_t'{id: ctl.key_id, pri: ctl.key_pri} : left;
        end
      end
      CELL_POP: begin
        slot_next = right;
      end
      CELL_TAKE_OUT: begin
        // close the gap from the first matching slot onwards
        if (seen_out) begin
          slot_next = right;
        end
      end
      default: begin
        slot_next = slot;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

@@ src/priority_queue_decrease_key.sv @@
`timescale 1ns / 1ps

// channel   | ports                 | handshake
// ----------+-----------------------+------------------------------------------
// command   | start, busy, item     | item taken at an edge with start & !busy
// result    | done, result          | done marks each item's result, high for a single cycle
//
// insert, remove front, clear and a refused upgrade make one pass through the cell row,
// then the result cycle, in which the next item may already be taken
// an upgrade that moves an entry makes a take-out pass and an insert pass
// through the row, then the result cycle
// reset empties the queue; slot contents are not cleared, only the count
// the receiver cannot stall: a result is shown for exactly one cycle

module priority_queue_decrease_key #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pqdk_pkg::item_in_t  item,
  output logic                done,
  output pqdk_pkg::item_out_t result
);
  import pqdk_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PASS1 = 3'b010,
    S_PASS2 = 3'b100
  } state_t;

  state_t            state, state_next;
  item_in_t          cur;
  logic [CW-1:0]     count, count_next;
  logic [STAT_W-1:0] status, status_next;
  logic [ID_W-1:0]   removed, removed_next;
  logic              done_next;
  cell_ctl_t         ctl;

  // cell row wiring
  slot_t              cell_slot      [DEPTH];
  logic               cell_after     [DEPTH];
  logic               cell_seen      [DEPTH];
  logic [PRI_W-1:0]   cell_found_pri [DEPTH];

  logic accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      slot_t            left_slot;
      logic             left_after;
      slot_t            right_slot;
      logic             seen_in;
      logic [PRI_W-1:0] found_pri_in;

      if (g == 0) begin : g_head
        // the head cell sees an open boundary on its left
        assign left_slot    = '0;
        assign left_after   = 1'b1;
        assign seen_in      = 1'b0;
        assign found_pri_in = '0;
      end else begin : g_body
        assign left_slot    = cell_slot[g-1];
        assign left_after   = cell_after[g-1];
        assign seen_in      = cell_seen[g-1];
        assign found_pri_in = cell_found_pri[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
        assign right_slot = '0;
      end else begin : g_inner
        assign right_slot = cell_slot[g+1];
      end

      pqdk_cell #(
        .INDEX (g),
        .CW    (CW)
      ) u_cell (
        .clk           (clk),
        .ctl           (ctl),
        .count         (count),
        .left          (left_slot),
        .left_after    (left_after),
        .right         (right_slot),
        .seen_in       (seen_in),
        .found_pri_in  (found_pri_in),
        .slot          (cell_slot[g]),
        .after         (cell_after[g]),
        .seen_out      (cell_seen[g]),
        .found_pri_out (cell_found_pri[g])
      );
    end
  endgenerate

  // command decode and sequencing
  always_comb begin
    state_next   = state;
    count_next   = count;
    status_next  = status;
    removed_next = removed;
    done_next    = 1'b0;
    ctl.op       = CELL_HOLD;
    ctl.key_id   = cur.entry_id;
    ctl.key_pri  = cur.entry_priority;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_PASS1;
        end
      end
      S_PASS1: begin
        status_next  = ST_OK;
        removed_next = '0;
        done_next    = 1'b1;
        state_next   = S_IDLE;
        unique case (cur.cmd)
          CMD_INSERT: begin
            if (count == FULL_COUNT) begin
              status_next = ST_FULL;
            end else begin
              ctl.op     = CELL_INSERT;
              count_next = count + CW'(1);
            end
          end
          CMD_REMOVE: begin
            if (count == '0) begin
              status_next = ST_EMPTY;
            end else begin
              ctl.op       = CELL_POP;
              removed_next = cell_slot[0].id;
              count_next   = count - CW'(1);
            end
          end
          CMD_UPGRADE: begin
            // the tail cell carries the search result of the whole row
            if (!cell_seen[DEPTH-1]) begin
              status_next = ST_NOT_FOUND;
            end else if (cell_found_pri[DEPTH-1] <= cur.entry_priority) begin
              status_next = ST_NOT_URGENT;
            end else begin
              ctl.op     = CELL_TAKE_OUT;
              count_next = count - CW'(1);
              done_next  = 1'b0;
              state_next = S_PASS2;
            end
          end
          CMD_CLEAR: begin
            count_next = '0;
          end
          default: begin
            count_next = count;
          end
        endcase
      end
      S_PASS2: begin
        // reinsert the upgraded entry at its new priority
        ctl.op     = CELL_INSERT;
        count_next = count + CW'(1);
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
    status  <= status_next;
    removed <= removed_next;
  end

  // front is read straight from the head cell
  always_comb begin
    result.status         = status;
    result.removed_id     = removed;
    result.front_id       = (count != '0) ? cell_slot[0].id : '0;
    result.front_priority = (count != '0) ? cell_slot[0].pri : '0;
    result.is_empty       = (count == '0);
    result.entry_count    = CNT_W'(count);
  end

endmodule

@@ src/pqdk_checker.sv @@
`timescale 1ns / 1ps

module pqdk_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input pqdk_pkg::item_out_t result
);
  import pqdk_pkg::*;

  // an accepted item keeps the block busy for its first pass
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accepting an item");

  // results never come in consecutive cycles
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back results");

  // an empty queue shows a zeroed front
  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    (done && result.is_empty) |->
      (result.front_id == '0 && result.front_priority == '0))
    else $error("empty queue with a non-zero front");

  // only a successful remove reports a removed id
  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_OK) |-> (result.removed_id == '0))
    else $error("removed id on a failed command");

endmodule

bind priority_queue_decrease_key pqdk_checker u_pqdk_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import pqdk_pkg::*;

  localparam int DEPTH = 16;

  logic      clk   = 1'b0;
  logic      rst   = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  item_in_t  item  = '0;
  logic      done;
  item_out_t result;

  priority_queue_decrease_key #(.DEPTH(DEPTH)) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done),
    .result(result)
  );

  always #10 clk = ~clk;

  // shadow copy of the queue, kept in queue order, front at index 0
  logic [ID_W-1:0]  shadow_id  [DEPTH];
  logic [PRI_W-1:0] shadow_pri [DEPTH];
  int unsigned      shadow_len = 0;

  // one outcome per accepted item, oldest first
  item_out_t   outcomes_due[$];
  int          errors        = 0;
  int          items_sent    = 0;
  int          results_seen  = 0;
  int unsigned status_tally[5] = '{default: 0};
  bit          steady        = 1'b0;   // set for a stretch with no gaps on the command side

  // close the gap left by the entry at pos
  function automatic void shadow_take_out(int unsigned pos);
    for (int unsigned i = pos; i + 1 < shadow_len; i++) begin
      shadow_id[i]  = shadow_id[i + 1];
      shadow_pri[i] = shadow_pri[i + 1];
    end
    shadow_len--;
  endfunction

  // new entry lands behind every entry of equal or more urgent priority
  function automatic void shadow_put_in(logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
    int unsigned pos;
    pos = 0;
    while (pos < shadow_len && shadow_pri[pos] <= pri) pos++;
    for (int unsigned i = shadow_len; i > pos; i--) begin
      shadow_id[i]  = shadow_id[i - 1];
      shadow_pri[i] = shadow_pri[i - 1];
    end
    shadow_id[pos]  = id;
    shadow_pri[pos] = pri;
    shadow_len++;
  endfunction

  // apply one command to the shadow queue and return the outcome it should report
  function automatic item_out_t queue_outcome(item_in_t it);
    item_out_t   r;
    int unsigned pos;
    r        = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_INSERT: begin
        if (shadow_len >= DEPTH) r.status = ST_FULL;
        else shadow_put_in(it.entry_id, it.entry_priority);
      end
      CMD_REMOVE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_id = shadow_id[0];
          shadow_take_out(0);
        end
      end
      CMD_UPGRADE: begin
        // first match from the front wins when ids repeat
        pos = 0;
        while (pos < shadow_len && shadow_id[pos] != it.entry_id) pos++;
        if (pos >= shadow_len) begin
          r.status = ST_NOT_FOUND;
        end else if (shadow_pri[pos] <= it.entry_priority) begin
          r.status = ST_NOT_URGENT;
        end else begin
          shadow_take_out(pos);
          shadow_put_in(it.entry_id, it.entry_priority);
        end
      end
      default: shadow_len = 0;
    endcase
    if (shadow_len > 0) begin
      r.front_id       = shadow_id[0];
      r.front_priority = shadow_pri[0];
    end
    r.is_empty    = (shadow_len == 0);
    r.entry_count = CNT_W'(shadow_len);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // results cannot be held off, so every strobe is taken at the edge closing its cycle
  always @(posedge clk) begin : check_results
    item_out_t want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (result.status < 5) status_tally[result.status]++;
      if (outcomes_due.size() == 0) begin
        $error("result arrived with no command outstanding");
        errors++;
      end else begin
        want = outcomes_due.pop_front();
        check_field("status",         32'(want.status),         32'(result.status));
        check_field("removed_id",     32'(want.removed_id),     32'(result.removed_id));
        check_field("front_id",       32'(want.front_id),       32'(result.front_id));
        check_field("front_priority", 32'(want.front_priority), 32'(result.front_priority));
        check_field("is_empty",       32'(want.is_empty),       32'(result.is_empty));
        check_field("entry_count",    32'(want.entry_count),    32'(result.entry_count));
      end
    end
  end

  // present one item and hold it until taken; start stays high afterwards so
  // back-to-back items never see start lowered and raised in one step
  task automatic send_item(input cmd_t cmd, input logic [ID_W-1:0] id,
                           input logic [PRI_W-1:0] pri);
    item_in_t it;
    it.cmd            = cmd;
    it.entry_id       = id;
    it.entry_priority = pri;
    // random gaps, which fall on whatever pass the block is in
    while (!steady && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    outcomes_due.push_back(queue_outcome(it));
    items_sent++;
  endtask

  // empty queue, a full queue, equal priorities, repeated ids and every status
  task automatic test_corner_cases();
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    send_item(CMD_REMOVE,  16'h1234, 16'h5678);   // remove from empty
    send_item(CMD_UPGRADE, 16'h0000, 16'h0000);   // upgrade on empty reports not found
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       begin id = 16'hFFFF; pri = 16'hFFFF; end
        1:       begin id = 16'h0000; pri = 16'h0000; end
        2:       begin id = 16'h0007; pri = 16'd300;  end
        3:       begin id = 16'h0007; pri = 16'd200;  end   // same id, more urgent copy
        default: begin id = 16'h5A00 + 16'(i); pri = 16'(100 * (i % 4)); end
      endcase
      send_item(CMD_INSERT, id, pri);
    end
    send_item(CMD_INSERT,  16'h1111, 16'h0000);   // full, dropped
    send_item(CMD_UPGRADE, 16'h7777, 16'h0000);   // id absent
    send_item(CMD_UPGRADE, 16'h0007, 16'd200);    // equal priority is not more urgent
    send_item(CMD_UPGRADE, 16'h0007, 16'd250);    // less urgent
    send_item(CMD_UPGRADE, 16'h0007, 16'h0000);   // moves behind the other zero entries
    send_item(CMD_UPGRADE, 16'hFFFF, 16'h0001);   // from the back of the queue
    send_item(CMD_REMOVE,  16'h0000, 16'h0000);
    send_item(CMD_CLEAR,   16'hFFFF, 16'hFFFF);
    send_item(CMD_CLEAR,   16'h0000, 16'h0000);   // clear when already empty
  endtask

  // mostly meaningful traffic: upgrades aimed at held ids with more urgent
  // priorities, fill and drain spells so the queue swings between empty and full
  task automatic test_random_traffic(input int count);
    int               mode;
    int               roll;
    int unsigned      pick;
    cmd_t             cmd;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    mode = 2;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) mode = $urandom_range(2);   // 0 fill, 1 drain, 2 balanced
      steady = (k >= 500 && k < 800);
      roll = $urandom_range(99);
      if (roll < 2) cmd = CMD_CLEAR;
      else if (roll < (mode == 0 ? 62 : mode == 1 ? 22 : 37)) cmd = CMD_INSERT;
      else if (roll < 77) cmd = CMD_UPGRADE;
      else cmd = (mode == 0 && roll < 85) ? CMD_INSERT : CMD_REMOVE;

      // ids: repeats of held ids, a small pool, or anything
      roll = $urandom_range(99);
      if (shadow_len > 0 && roll < 33) id = shadow_id[$urandom_range(shadow_len - 1)];
      else if (roll < 66) id = 16'($urandom_range(15));
      else id = 16'($urandom_range(16'hFFFF));
      // narrow priorities give plenty of ties
      pri = ($urandom_range(1) == 0) ? 16'($urandom_range(7)) : 16'($urandom_range(16'hFFFF));

      if (cmd == CMD_UPGRADE && shadow_len > 0 && $urandom_range(99) < 75) begin
        pick = $urandom_range(shadow_len - 1);
        id   = shadow_id[pick];
        if (shadow_pri[pick] > 0) pri = 16'($urandom_range(shadow_pri[pick] - 16'd1));
        else pri = 16'($urandom_range(3));   // nothing is more urgent than zero
      end
      send_item(cmd, id, pri);
    end
    steady = 1'b0;
  endtask

  // stop sending, wait for outstanding results, then a little slack
  task automatic wait_for_results();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (outcomes_due.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (outcomes_due.size() != 0) begin
      $error("%0d results never arrived", outcomes_due.size());
      errors++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_random_traffic(1325);
    wait_for_results();
    $display("%0d commands sent, %0d results checked", items_sent, results_seen);
    $display("statuses: ok %0d, empty %0d, not found %0d, not urgent %0d, full %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
